@@ rtl/lba_pkg.sv @@
// ----------------------------------------------------------------------------
// lba_pkg
// Shared widths, codes and helpers for the binary-lifting ancestor block.
// ----------------------------------------------------------------------------
package lba_pkg;

	// node entries are 11-bit two's complement, all ones marks no node
	localparam int ENTRY_W = 11;
	localparam int COUNT_W = 11;
	localparam int DEPTH_W = 10;
	localparam int PADDR_W = 3;

	localparam logic [ENTRY_W-1:0] NONE_ENTRY = '1;

	localparam logic [1:0] KIND_LOAD = 2'd0;
	localparam logic [1:0] KIND_KTH  = 2'd1;
	localparam logic [1:0] KIND_LCA  = 2'd2;
	localparam logic [1:0] KIND_NOP  = 2'd3;

	// word index of each register
	localparam logic [0:0] REG_NODE_COUNT = 1'b0;

	typedef logic [ENTRY_W-1:0] entry_t;

	typedef struct packed {
		logic               wr;
		logic [COUNT_W-1:0] count;
	} cfg_t;

	// a stored parent link only counts if it names another node in use
	function automatic entry_t sanitize(input entry_t raw, input entry_t self,
		input logic [COUNT_W-1:0] cnt);
		if (raw[ENTRY_W-1] || raw >= cnt || raw == self) begin
			return NONE_ENTRY;
		end
		return raw;
	endfunction

endpackage

@@ rtl/lba_ram.sv @@
// ----------------------------------------------------------------------------
// lba_ram
// Simple dual-port synchronous memory, one write and one registered read.
// ----------------------------------------------------------------------------
module lba_ram #(
	parameter int WORDS = 1024,
	parameter int WIDTH = 11,
	localparam int AW = $clog2(WORDS)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [WORDS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/lba_cfg.sv @@
// ----------------------------------------------------------------------------
// lba_cfg
// APB register file holding node_count, flags each write to the engine.
// ----------------------------------------------------------------------------
module lba_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [lba_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	output lba_pkg::cfg_t                cfg
);
	import lba_pkg::*;

	logic [COUNT_W-1:0] count_q;
	logic               hit;

	assign hit    = paddr[PADDR_W-1:2] == REG_NODE_COUNT;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= COUNT_W'(1);
		end else if (cfg.wr) begin
			count_q <= pwdata[COUNT_W-1:0];
		end
	end

	assign cfg.wr    = psel && penable && pwrite && pready && hit;
	assign cfg.count = count_q;
	assign prdata    = hit ? 32'(count_q) : '0;

endmodule

@@ rtl/lba_engine.sv @@
// ----------------------------------------------------------------------------
// lba_engine
// Sequencer around the ancestor and depth memories: load, rebuild, queries.
// ----------------------------------------------------------------------------
module lba_engine #(
	parameter int NODES  = 1024,
	parameter int LEVELS = 11
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  lba_pkg::cfg_t                      cfg,
	input  logic                               start,
	output logic                               busy,
	input  logic [1:0]                         kind,
	input  logic [9:0]                         node,
	input  logic signed [lba_pkg::ENTRY_W-1:0] parent,
	input  logic [10:0]                        steps,
	input  logic [9:0]                         second_node,
	output logic                               done,
	output logic signed [lba_pkg::ENTRY_W-1:0] answer
);
	import lba_pkg::*;

	localparam int IW   = $clog2(NODES);
	localparam int LW   = $clog2(LEVELS);
	localparam int LCW  = $clog2(LEVELS + 1);
	localparam int JAW  = IW + LW;
	localparam int SUMW = ((LEVELS > DEPTH_W) ? LEVELS : DEPTH_W) + 1;
	localparam int TOP  = LEVELS - 1;

	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_B_RD  = 5'd1;
	localparam logic [4:0] S_B_W0  = 5'd2;
	localparam logic [4:0] S_B_W1  = 5'd3;
	localparam logic [4:0] S_D_RD  = 5'd4;
	localparam logic [4:0] S_D_W   = 5'd5;
	localparam logic [4:0] S_Q_GO  = 5'd6;
	localparam logic [4:0] S_K_CHK = 5'd7;
	localparam logic [4:0] S_K_DEP = 5'd8;
	localparam logic [4:0] S_L_RD  = 5'd9;
	localparam logic [4:0] S_L_W   = 5'd10;
	localparam logic [4:0] S_C_CHK = 5'd11;
	localparam logic [4:0] S_C_D0  = 5'd12;
	localparam logic [4:0] S_C_D1  = 5'd13;
	localparam logic [4:0] S_C_RA  = 5'd14;
	localparam logic [4:0] S_C_RB  = 5'd15;
	localparam logic [4:0] S_C_CMP = 5'd16;
	localparam logic [4:0] S_C_FIN = 5'd17;

	function automatic logic [IW-1:0] to_idx(input entry_t e);
		logic [31:0] w;
		w = 32'(e);
		return w[IW-1:0];
	endfunction

	logic [4:0]         state_q;
	logic               stale_q;
	logic               lca_q;
	logic [9:0]         node_q;
	logic [9:0]         sec_q;
	logic [10:0]        steps_q;
	logic [IW-1:0]      v_q;
	logic [LCW-1:0]     lv_q;
	entry_t             x_q;
	entry_t             b_q;
	entry_t             pa_q;
	entry_t             mid_q;
	logic [DEPTH_W-1:0] d_q;
	logic [DEPTH_W-1:0] dx_q;
	logic [10:0]        amt_q;
	entry_t             ans_q;
	logic               done_q;

	logic               j_we;
	logic [JAW-1:0]     j_waddr;
	entry_t             j_wdata;
	logic [JAW-1:0]     j_raddr;
	entry_t             j_rdata;
	logic               d_we;
	logic [IW-1:0]      d_waddr;
	logic [DEPTH_W-1:0] d_wdata;
	logic [IW-1:0]      d_raddr;
	logic [DEPTH_W-1:0] d_rdata;

	logic [COUNT_W-1:0] cnt;
	logic [COUNT_W-1:0] cnt_m1;
	logic [DEPTH_W-1:0] cap;
	logic               accept;
	logic               node_ok;
	logic [LW-1:0]      lvi;
	logic [LW-1:0]      lvi_prev;
	entry_t             self_e;
	logic               rd_lv0;
	entry_t             j_clean;
	logic [SUMW-1:0]    d_sum;
	logic               take;
	logic [DEPTH_W-1:0] d_next;
	logic               last_v;
	logic               last_lv;
	logic               b_entry_done;
	logic               d_finish;
	logic               diverge;
	logic               dead;
	entry_t             a_new;
	logic               lift_end;

	lba_ram #(.WORDS(NODES << LW), .WIDTH(ENTRY_W)) u_jump (
		.clk   (clk),
		.we    (j_we),
		.waddr (j_waddr),
		.wdata (j_wdata),
		.raddr (j_raddr),
		.rdata (j_rdata)
	);

	lba_ram #(.WORDS(NODES), .WIDTH(DEPTH_W)) u_depth (
		.clk   (clk),
		.we    (d_we),
		.waddr (d_waddr),
		.wdata (d_wdata),
		.raddr (d_raddr),
		.rdata (d_rdata)
	);

	assign cnt      = (32'(cfg.count) < NODES) ? cfg.count : COUNT_W'(NODES);
	assign cnt_m1   = (cnt == '0) ? '0 : cnt - 1'b1;
	// climb limit saturates at the top of the depth range
	assign cap      = cnt_m1[COUNT_W-1] ? '1 : cnt_m1[DEPTH_W-1:0];
	assign busy     = state_q != S_IDLE;
	assign accept   = start && !busy;
	assign node_ok  = 32'(node) < NODES;
	assign lvi      = lv_q[LW-1:0];
	assign lvi_prev = LW'(lv_q - 1'b1);

	// level 0 holds raw parents, cleaned on every read
	always_comb begin
		self_e = x_q;
		rd_lv0 = lv_q == '0;
		case (state_q)
			S_B_W0: begin
				self_e = ENTRY_W'(v_q);
				rd_lv0 = lv_q == LCW'(1);
			end
			S_B_W1: begin
				self_e = mid_q;
				rd_lv0 = lv_q == LCW'(1);
			end
			S_C_CMP: begin
				self_e = b_q;
			end
			default: begin
			end
		endcase
	end

	assign j_clean = rd_lv0 ? sanitize(j_rdata, self_e, cnt) : j_rdata;

	assign d_sum   = SUMW'(d_q) + (SUMW'(1) << lv_q);
	assign take    = (j_clean != NONE_ENTRY) && (d_sum <= SUMW'(cap));
	assign d_next  = take ? d_sum[DEPTH_W-1:0] : d_q;

	assign last_v  = (32'(v_q) + 1) >= 32'(cnt);
	assign last_lv = lv_q == LCW'(TOP);
	assign b_entry_done = ((state_q == S_B_W0) && (j_clean == NONE_ENTRY)) ||
		(state_q == S_B_W1);
	assign d_finish = (state_q == S_D_W) && !(last_lv && take) && (lv_q == '0);

	assign diverge  = pa_q != j_clean;
	assign dead     = diverge && ((pa_q == NONE_ENTRY) || (j_clean == NONE_ENTRY));
	assign a_new    = diverge ? pa_q : x_q;
	assign lift_end = (lv_q == LCW'(LEVELS)) || (x_q == NONE_ENTRY);

	always_comb begin
		j_we    = 1'b0;
		j_waddr = {to_idx({1'b0, node}), LW'(0)};
		j_wdata = unsigned'(parent);
		j_raddr = '0;
		d_we    = d_finish;
		d_waddr = v_q;
		d_wdata = d_next;
		d_raddr = to_idx({1'b0, node_q});
		case (state_q)
			S_IDLE: begin
				j_we = accept && (kind == KIND_LOAD) && node_ok;
			end
			S_B_RD: begin
				j_raddr = {v_q, lvi_prev};
			end
			S_B_W0: begin
				j_raddr = {to_idx(j_clean), lvi_prev};
				j_we    = j_clean == NONE_ENTRY;
				j_waddr = {v_q, lvi};
				j_wdata = NONE_ENTRY;
			end
			S_B_W1: begin
				j_we    = 1'b1;
				j_waddr = {v_q, lvi};
				j_wdata = j_clean;
			end
			S_D_RD, S_L_RD, S_C_RA: begin
				j_raddr = {to_idx(x_q), lvi};
			end
			S_C_D0: begin
				d_raddr = to_idx({1'b0, sec_q});
			end
			S_C_RB: begin
				j_raddr = {to_idx(b_q), lvi};
			end
			S_C_CMP: begin
				j_raddr = {to_idx(a_new), LW'(0)};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			stale_q <= 1'b1;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg.wr) begin
				stale_q <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (kind == KIND_LOAD) begin
							if (node_ok) begin
								stale_q <= 1'b1;
							end
						end else if (kind == KIND_KTH || kind == KIND_LCA) begin
							lca_q   <= kind == KIND_LCA;
							node_q  <= node;
							sec_q   <= second_node;
							steps_q <= steps;
							if (!stale_q) begin
								state_q <= S_Q_GO;
							end else if (cnt == '0) begin
								stale_q <= 1'b0;
								state_q <= S_Q_GO;
							end else begin
								v_q     <= '0;
								lv_q    <= LCW'(1);
								state_q <= S_B_RD;
							end
						end
					end
				end
				S_B_RD: begin
					state_q <= S_B_W0;
				end
				S_B_W0: begin
					if (j_clean != NONE_ENTRY) begin
						mid_q   <= j_clean;
						state_q <= S_B_W1;
					end
				end
				S_B_W1: begin
				end
				S_D_RD: begin
					state_q <= S_D_W;
				end
				S_D_W: begin
					// greedy descent, the top level may repeat
					if (last_lv && take) begin
						x_q     <= j_clean;
						d_q     <= d_next;
						state_q <= S_D_RD;
					end else if (lv_q == '0) begin
						if (last_v) begin
							stale_q <= 1'b0;
							state_q <= S_Q_GO;
						end else begin
							v_q     <= v_q + 1'b1;
							x_q     <= ENTRY_W'(32'(v_q) + 1);
							d_q     <= '0;
							lv_q    <= LCW'(TOP);
							state_q <= S_D_RD;
						end
					end else begin
						if (take) begin
							x_q <= j_clean;
						end
						d_q     <= d_next;
						lv_q    <= lv_q - 1'b1;
						state_q <= S_D_RD;
					end
				end
				S_Q_GO: begin
					state_q <= lca_q ? S_C_CHK : S_K_CHK;
				end
				S_K_CHK: begin
					if ({1'b0, node_q} >= cnt) begin
						ans_q   <= NONE_ENTRY;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_K_DEP;
					end
				end
				S_K_DEP: begin
					if (steps_q > {1'b0, d_rdata}) begin
						ans_q   <= NONE_ENTRY;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						amt_q   <= steps_q;
						x_q     <= {1'b0, node_q};
						lv_q    <= '0;
						state_q <= S_L_RD;
					end
				end
				S_L_RD: begin
					if (lift_end) begin
						if (!lca_q) begin
							ans_q   <= x_q;
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else if (x_q == NONE_ENTRY || x_q == b_q) begin
							ans_q   <= x_q;
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							lv_q    <= LCW'(TOP);
							state_q <= S_C_RA;
						end
					end else if (amt_q[0]) begin
						state_q <= S_L_W;
					end else begin
						amt_q <= amt_q >> 1;
						lv_q  <= lv_q + 1'b1;
					end
				end
				S_L_W: begin
					x_q     <= j_clean;
					amt_q   <= amt_q >> 1;
					lv_q    <= lv_q + 1'b1;
					state_q <= S_L_RD;
				end
				S_C_CHK: begin
					if ({1'b0, node_q} >= cnt || {1'b0, sec_q} >= cnt) begin
						ans_q   <= NONE_ENTRY;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_C_D0;
					end
				end
				S_C_D0: begin
					dx_q    <= d_rdata;
					state_q <= S_C_D1;
				end
				S_C_D1: begin
					// lift the deeper node first
					if (dx_q < d_rdata) begin
						x_q   <= {1'b0, sec_q};
						b_q   <= {1'b0, node_q};
						amt_q <= {1'b0, d_rdata - dx_q};
					end else begin
						x_q   <= {1'b0, node_q};
						b_q   <= {1'b0, sec_q};
						amt_q <= {1'b0, dx_q - d_rdata};
					end
					lv_q    <= '0;
					state_q <= S_L_RD;
				end
				S_C_RA: begin
					state_q <= S_C_RB;
				end
				S_C_RB: begin
					pa_q    <= j_clean;
					state_q <= S_C_CMP;
				end
				S_C_CMP: begin
					if (dead) begin
						ans_q   <= NONE_ENTRY;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						x_q <= a_new;
						if (diverge) begin
							b_q <= j_clean;
						end
						if (lv_q == '0) begin
							state_q <= S_C_FIN;
						end else begin
							lv_q    <= lv_q - 1'b1;
							state_q <= S_C_RA;
						end
					end
				end
				S_C_FIN: begin
					ans_q   <= j_clean;
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			// end of one table entry during the level build
			if (b_entry_done) begin
				if (!last_v) begin
					v_q     <= v_q + 1'b1;
					state_q <= S_B_RD;
				end else if (!last_lv) begin
					v_q     <= '0;
					lv_q    <= lv_q + 1'b1;
					state_q <= S_B_RD;
				end else begin
					v_q     <= '0;
					x_q     <= '0;
					d_q     <= '0;
					lv_q    <= LCW'(TOP);
					state_q <= S_D_RD;
				end
			end
		end
	end

	assign done   = done_q;
	assign answer = signed'(ans_q);

endmodule

@@ rtl/tree_ancestor_binary_lifting.sv @@
// ----------------------------------------------------------------------------
// tree_ancestor_binary_lifting
// Rooted tree store answering kth-ancestor and lowest-common-ancestor queries.
// ----------------------------------------------------------------------------
// Usage: a command word is taken when start is high and busy is low. kind 0
// loads one parent link (parent -1 marks a root) and completes in that same
// cycle, busy stays low and no result follows. kind 1 asks for the ancestor
// steps levels above node, kind 2 for the common ancestor of node and
// second_node; each gives one answer word, shown with done high for exactly
// one cycle, -1 meaning no such node. kind 3 is dropped.
// The first query after a load or a node_count write rebuilds the ancestor
// table: first every level for all nodes, then the depth of each node.
// Query time is set by the single read port of the ancestor memory: each
// dependent lookup waits for the registered read of the one before it.
// Words are handled one at a time.
// node_count sits on the APB port at byte address 0; write it only while the
// block is idle. Reset sets node_count to 1 and marks the tables stale; the
// memories themselves are not cleared. There is no back-pressure on results.
// ----------------------------------------------------------------------------
module tree_ancestor_binary_lifting #(
	parameter int NODES  = 1024,
	parameter int LEVELS = 11
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [lba_pkg::PADDR_W-1:0]        paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready,
	input  logic                               start,
	output logic                               busy,
	input  logic [1:0]                         kind,
	input  logic [9:0]                         node,
	input  logic signed [lba_pkg::ENTRY_W-1:0] parent,
	input  logic [10:0]                        steps,
	input  logic [9:0]                         second_node,
	output logic                               done,
	output logic signed [lba_pkg::ENTRY_W-1:0] answer
);
	import lba_pkg::*;

	cfg_t cfg;

	lba_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	lba_engine #(.NODES(NODES), .LEVELS(LEVELS)) u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.start       (start),
		.busy        (busy),
		.kind        (kind),
		.node        (node),
		.parent      (parent),
		.steps       (steps),
		.second_node (second_node),
		.done        (done),
		.answer      (answer)
	);

endmodule

@@ rtl/lba_checker.sv @@
// ----------------------------------------------------------------------------
// lba_checker
// Port-level checks on command and result timing, bound to the top level.
// ----------------------------------------------------------------------------
module lba_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               start,
	input logic                               busy,
	input logic [1:0]                         kind,
	input logic                               done,
	input logic signed [lba_pkg::ENTRY_W-1:0] answer
);
	import lba_pkg::*;

	// busy only drops when an answer goes out
	a_fall_gives_word: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result word");

	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (kind == KIND_KTH || kind == KIND_LCA)) |=> busy)
		else $error("query taken but block not busy");

	a_load_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && kind == KIND_LOAD) |=> (!busy && !done))
		else $error("load caused work or a result");

	a_none_code: assert property (@(posedge clk) disable iff (!arst_n)
		(done && answer[ENTRY_W-1]) |-> (&answer))
		else $error("negative answer other than none");

endmodule

bind tree_ancestor_binary_lifting lba_checker u_lba_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.kind   (kind),
	.done   (done),
	.answer (answer)
);
